>>> src/erma_pkg.sv
// erma_pkg: shared constants, widths and handshake structs for the
// event rate moving average block; no dependencies
package erma_pkg;

   // field widths
   localparam int COUNT_W = 16;
   localparam int MS_W = 16;
   localparam int RATE_W = 24;
   localparam int SAMPLE_W = 3;

   // moving average window
   localparam int WINDOW_DEPTH = 5;
   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int TOTAL_W = RATE_W + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 0);

   // rate scaling: count * 1000 ms/s, then 8 fraction bits
   localparam int RATE_SCALE = 1000;
   localparam int SCALE_W = $clog2(RATE_SCALE + 1);
   localparam int FRAC_W = 8;
   localparam int SCALED_W = COUNT_W + SCALE_W;

   // shared serial divider
   localparam int DIVIDEND_W = SCALED_W + FRAC_W;
   localparam int DIVISOR_W = MS_W;
   localparam int QUOT_W = RATE_W;
   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   // input action codes
   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> src/erma_div.sv
// erma_div: restoring divider, one quotient bit per cycle, with a flag
// for quotients that do not fit the result width; depends on erma_pkg
module erma_div (
   input  logic                             clock,
   input  logic                             reset,
   input  erma_pkg::div_ctrl_type           div_ctrl,
   input  logic [erma_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [erma_pkg::DIVISOR_W-1:0]   divisor,
   output erma_pkg::div_stat_type           div_stat,
   output logic [erma_pkg::QUOT_W-1:0]      quotient,
   output logic                             overflow
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [erma_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [erma_pkg::DIVISOR_W:0]       rem_ff, rem_in;
   logic [erma_pkg::DIVIDEND_W-1:0]    num_ff, num_in;
   logic [erma_pkg::DIVISOR_W-1:0]     dvs_ff, dvs_in;
   logic [erma_pkg::QUOT_W-1:0]        quo_ff, quo_in;
   logic                               ovf_ff, ovf_in;
   logic [erma_pkg::DIVISOR_W:0]       rem_shift;
   logic                               fits;

   // one trial subtract per cycle
   assign rem_shift = {rem_ff[erma_pkg::DIVISOR_W-1:0], num_ff[erma_pkg::DIVIDEND_W-1]};
   assign fits = rem_shift >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (div_ctrl.start) begin
         busy_in = 1'b1;
         step_in = erma_pkg::STEP_W'(erma_pkg::DIVIDEND_W);
         rem_in = '0;
         num_in = dividend;
         dvs_in = divisor;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
         num_in = {num_ff[erma_pkg::DIVIDEND_W-2:0], 1'b0};
         quo_in = {quo_ff[erma_pkg::QUOT_W-2:0], fits};
         // a bit leaving the top means the quotient is too wide
         ovf_in = ovf_ff | quo_ff[erma_pkg::QUOT_W-1];
         step_in = step_ff - erma_pkg::STEP_W'(1);
         if (step_ff == erma_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_busy_counts: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff != '0)
      else $error("divider busy with an exhausted step count");
`endif

endmodule

>>> src/event_rate_moving_average_top.sv
// event_rate_moving_average_top: frame counter, rate measurement and
// moving average over a small ring; depends on erma_pkg and erma_div
//
// channel   direction  ports                                  beat
// req       in         req_valid/ready, action, elapsed_ms    frame event or sample tick
// rsp       out        rsp_valid/ready, average_rate,         one per sample tick
//                      instant_rate, samples_in_window
//
// a frame event beat keeps req_ready high; a tick beat holds req_ready low
// through ST_SCALE, ST_RATE, ST_UPDATE, ST_AVG and ST_DONE, mostly held by
// the bit-serial divider, which is used twice: once for the rate and
// once for the average; the result loads onto rsp on leaving ST_DONE
// req_ready is low while a tick is in progress; a result waiting on rsp
// does not block frame events, only the finish of the next tick
// synchronous reset clears the counter, ring pointers and total; ring
// entries are not reset, an entry is only read once the ring is full
module event_rate_moving_average_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [erma_pkg::MS_W-1:0]         req_elapsed_ms,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [erma_pkg::RATE_W-1:0]       rsp_average_rate,
   output logic [erma_pkg::RATE_W-1:0]       rsp_instant_rate,
   output logic [erma_pkg::SAMPLE_W-1:0]     rsp_samples_in_window
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCALE  = 6'b000010,
      ST_RATE   = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_AVG    = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                          state_ff, state_in;
   logic [erma_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [erma_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [erma_pkg::FILL_W-1:0]        fill_ff, fill_in;
   logic [erma_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // payload registers, no reset
   logic [erma_pkg::SCALED_W-1:0]      scaled_ff, scaled_in;
   logic [erma_pkg::MS_W-1:0]          ms_ff, ms_in;
   logic [erma_pkg::RATE_W-1:0]        rate_ff, rate_in;
   logic [erma_pkg::RATE_W-1:0]        avg_ff, avg_in;
   logic [erma_pkg::RATE_W-1:0]        ring_ff [erma_pkg::WINDOW_DEPTH];
   logic [erma_pkg::RATE_W-1:0]        out_avg_ff, out_avg_in;
   logic [erma_pkg::RATE_W-1:0]        out_rate_ff, out_rate_in;
   logic [erma_pkg::SAMPLE_W-1:0]      out_fill_ff, out_fill_in;

   erma_pkg::div_ctrl_type             div_ctrl;
   erma_pkg::div_stat_type             div_stat;
   logic [erma_pkg::DIVIDEND_W-1:0]    div_dividend;
   logic [erma_pkg::DIVISOR_W-1:0]     div_divisor;
   logic [erma_pkg::QUOT_W-1:0]        div_quotient;
   logic                               div_overflow;

   logic                               req_beat;
   logic                               ring_full;
   logic [erma_pkg::RATE_W-1:0]        old_rate;
   logic                               ring_we;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_beat = req_valid & req_ready;

   // the entry at the write slot holds data only once the ring has wrapped
   assign ring_full = (fill_ff == erma_pkg::FILL_W'(erma_pkg::WINDOW_DEPTH));
   assign old_rate = ring_full ? ring_ff[slot_ff] : '0;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      slot_in = slot_ff;
      fill_in = fill_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      scaled_in = scaled_ff;
      ms_in = ms_ff;
      rate_in = rate_ff;
      avg_in = avg_ff;
      out_avg_in = out_avg_ff;
      out_rate_in = out_rate_ff;
      out_fill_in = out_fill_ff;
      ring_we = 1'b0;
      div_ctrl.start = 1'b0;
      div_dividend = {scaled_ff, erma_pkg::FRAC_W'(0)};
      div_divisor = ms_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (req_action == erma_pkg::ACT_FRAME) begin
                  // saturating frame counter
                  if (count_ff != erma_pkg::COUNT_MAX) begin
                     count_in = count_ff + erma_pkg::COUNT_W'(1);
                  end
               end else begin
                  // count * 1000 in one narrow multiply
                  scaled_in = erma_pkg::SCALED_W'(count_ff) *
                              erma_pkg::SCALED_W'(erma_pkg::RATE_SCALE);
                  ms_in = req_elapsed_ms;
                  count_in = '0;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            div_ctrl.start = 1'b1;
            state_in = ST_RATE;
         end
         ST_RATE: begin
            if (div_stat.done) begin
               // zero elapsed time: full scale unless nothing was counted
               if (ms_ff == '0) begin
                  rate_in = (scaled_ff != '0) ? erma_pkg::RATE_MAX : '0;
               end else begin
                  rate_in = div_overflow ? erma_pkg::RATE_MAX : div_quotient;
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            total_in = total_ff - erma_pkg::TOTAL_W'(old_rate) +
                       erma_pkg::TOTAL_W'(rate_ff);
            ring_we = 1'b1;
            slot_in = (slot_ff == erma_pkg::SLOT_W'(erma_pkg::WINDOW_DEPTH - 1)) ?
                      '0 : slot_ff + erma_pkg::SLOT_W'(1);
            if (!ring_full) begin
               fill_in = fill_ff + erma_pkg::FILL_W'(1);
            end
            // average = new total / new fill count
            div_ctrl.start = 1'b1;
            div_dividend = erma_pkg::DIVIDEND_W'(total_in);
            div_divisor = erma_pkg::DIVISOR_W'(fill_in);
            state_in = ST_AVG;
         end
         ST_AVG: begin
            if (div_stat.done) begin
               avg_in = div_quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // load the output register once the previous result is gone
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               out_avg_in = avg_ff;
               out_rate_in = rate_ff;
               out_fill_in = erma_pkg::SAMPLE_W'(fill_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         slot_ff <= '0;
         fill_ff <= '0;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
      ms_ff <= ms_in;
      rate_ff <= rate_in;
      avg_ff <= avg_in;
      out_avg_ff <= out_avg_in;
      out_rate_ff <= out_rate_in;
      out_fill_ff <= out_fill_in;
      if (ring_we) begin
         ring_ff[slot_ff] <= rate_ff;
      end
   end

   // shared bit-serial divider: rate first, then average
   erma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctrl (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_stat (div_stat),
      .quotient (div_quotient),
      .overflow (div_overflow)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_average_rate = out_avg_ff;
   assign rsp_instant_rate = out_rate_ff;
   assign rsp_samples_in_window = out_fill_ff;

`ifndef ASSERT_OFF
   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !ring_full |-> slot_ff == erma_pkg::SLOT_W'(fill_ff))
      else $error("ring slot out of step with fill count");
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider started while busy");
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the finish step");
   a_frame_counts: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_action == erma_pkg::ACT_FRAME && count_ff != erma_pkg::COUNT_MAX
      |=> count_ff == $past(count_ff) + erma_pkg::COUNT_W'(1))
      else $error("frame event not counted");
`endif

endmodule
